/* design/imh_pkg.sv */
// Package for the indexed min-heap queue: sizes, operation and status codes.
// Used by the top level and the checker; no dependencies.
package imh_pkg;
	localparam int CAPACITY     = 1024;
	localparam int NODE_HANDLES = 1024;
	localparam int COST_BITS    = 32;
	localparam int SLOT_W       = $clog2(CAPACITY);
	localparam int NODE_W       = 10;
	localparam int CNT_W        = SLOT_W + 1;
	localparam int ENTRY_W      = NODE_W + COST_BITS;
	localparam int PM_W         = SLOT_W + 1;

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_CHANGE = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;
endpackage

/* design/imh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/indexed_min_heap_queue_top.sv */
// Channel  | valid     | ready     | payload
// input    | in_valid  | in_ready  | func, node_id, cost_key
// output   | out_valid | out_ready | out_node_id, out_cost, status, entry_count, heap_empty
// One transaction at a time, paced by the single read port of the slot RAM.
// Push/change climb by parent compares; a key change to a handle already
// present that does not climb descends by child compares instead. Pop
// moves the last entry to the root and sinks it by child compares.
// After reset a clearing pass sweeps the position map before in_ready.
// A finished result waits in the output register; the next transaction is taken meanwhile.
// Holds the heap controller; depends on imh_pkg and imh_ram.
module indexed_min_heap_queue_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [imh_pkg::NODE_W-1:0]  node_id,
	input  logic [31:0]                 cost_key,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [imh_pkg::NODE_W-1:0]  out_node_id,
	output logic [31:0]                 out_cost,
	output logic [1:0]                  status,
	output logic [imh_pkg::CNT_W-1:0]   entry_count,
	output logic                        heap_empty
);
	import imh_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_CLR   = 15'b000000000000010,
		S_PMRD  = 15'b000000000000100,
		S_PMCHK = 15'b000000000001000,
		S_POP0  = 15'b000000000010000,
		S_POP1  = 15'b000000000100000,
		S_POP2  = 15'b000000001000000,
		S_UPA   = 15'b000000010000000,
		S_UPB   = 15'b000000100000000,
		S_DNA   = 15'b000001000000000,
		S_DNB   = 15'b000010000000000,
		S_DNC   = 15'b000100000000000,
		S_FIN   = 15'b001000000000000,
		S_ROOT  = 15'b010000000000000,
		S_RWAIT = 15'b100000000000000
	} state_t;

	state_t               state_q;
	logic [NODE_W-1:0]    clr_q;
	logic [CNT_W-1:0]     count_q;
	logic [1:0]           func_q;
	logic [SLOT_W-1:0]    pos_q;
	logic [NODE_W-1:0]    cur_h_q;
	logic [COST_BITS-1:0] cur_c_q;
	logic                 moved_q;
	logic                 rekey_q;
	logic [1:0]           status_q;
	logic                 popped_q;
	logic [NODE_W-1:0]    pop_h_q;
	logic [COST_BITS-1:0] pop_c_q;
	logic [NODE_W-1:0]    left_h_q;
	logic [COST_BITS-1:0] left_c_q;

	logic                 slot_we;
	logic [SLOT_W-1:0]    slot_waddr, slot_raddr;
	logic [ENTRY_W-1:0]   slot_wdata, slot_rd;
	logic                 pm_we;
	logic [NODE_W-1:0]    pm_waddr, pm_raddr;
	logic [PM_W-1:0]      pm_wdata, pm_rd;

	logic [NODE_W-1:0]    rd_h;
	logic [COST_BITS-1:0] rd_c;
	logic [SLOT_W-1:0]    parent;
	logic [CNT_W-1:0]     left_i;
	logic [CNT_W:0]       right_i;
	logic                 left_ok, right_ok, pick_r;
	logic [NODE_W-1:0]    pick_h;
	logic [COST_BITS-1:0] pick_c;
	logic [SLOT_W-1:0]    pick_i;
	logic [CNT_W-1:0]     count_m1;

	imh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rd)
	);

	imh_ram #(.WIDTH(PM_W), .DEPTH(NODE_HANDLES)) u_pos (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rd)
	);

	assign rd_h     = slot_rd[ENTRY_W-1:COST_BITS];
	assign rd_c     = slot_rd[COST_BITS-1:0];
	assign parent   = (pos_q - SLOT_W'(1)) >> 1;
	assign left_i   = {pos_q, 1'b1};
	assign right_i  = {1'b0, left_i} + (CNT_W+1)'(1);
	assign left_ok  = left_i < count_q;
	assign right_ok = right_i < {1'b0, count_q};
	assign pick_r   = right_ok && (left_c_q > rd_c);
	assign pick_h   = pick_r ? rd_h : left_h_q;
	assign pick_c   = pick_r ? rd_c : left_c_q;
	assign pick_i   = pick_r ? right_i[SLOT_W-1:0] : left_i[SLOT_W-1:0];
	assign count_m1 = count_q - CNT_W'(1);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = pos_q;
		slot_wdata = {cur_h_q, cur_c_q};
		slot_raddr = '0;
		pm_we      = 1'b0;
		pm_waddr   = cur_h_q;
		pm_wdata   = {1'b1, pos_q};
		pm_raddr   = cur_h_q;
		case (state_q)
			S_CLR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
			end
			S_POP1: slot_raddr = count_m1[SLOT_W-1:0];
			S_POP2: begin
				pm_we    = 1'b1;
				pm_waddr = pop_h_q;
				pm_wdata = '0;
			end
			S_UPA: slot_raddr = parent;
			S_UPB: begin
				if (rd_c > cur_c_q) begin
					slot_we    = 1'b1;
					slot_wdata = slot_rd;
					pm_we      = 1'b1;
					pm_waddr   = rd_h;
				end
			end
			S_DNA: slot_raddr = left_i[SLOT_W-1:0];
			S_DNB: slot_raddr = right_i[SLOT_W-1:0];
			S_DNC: begin
				if (pick_c < cur_c_q) begin
					slot_we    = 1'b1;
					slot_wdata = {pick_h, pick_c};
					pm_we      = 1'b1;
					pm_waddr   = pick_h;
				end
			end
			S_FIN: begin
				slot_we = 1'b1;
				pm_we   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_RWAIT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODE_HANDLES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q   <= func;
						cur_h_q  <= node_id;
						cur_c_q  <= cost_key[COST_BITS-1:0];
						status_q <= ST_OK;
						popped_q <= 1'b0;
						moved_q  <= 1'b0;
						rekey_q  <= 1'b0;
						if (func == FUNC_PUSH || func == FUNC_CHANGE) begin
							state_q <= S_PMRD;
						end else if (func == FUNC_POP) begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_ROOT;
							end else begin
								state_q <= S_POP0;
							end
						end else begin
							state_q <= S_ROOT;
						end
					end
				end
				S_PMRD: state_q <= S_PMCHK;
				S_PMCHK: begin
					if (pm_rd[PM_W-1]) begin
						pos_q   <= pm_rd[SLOT_W-1:0];
						rekey_q <= 1'b1;
						state_q <= S_UPA;
					end else if (func_q == FUNC_CHANGE) begin
						status_q <= ST_ABSENT;
						state_q  <= S_ROOT;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						status_q <= ST_FULL;
						state_q  <= S_ROOT;
					end else begin
						pos_q   <= count_q[SLOT_W-1:0];
						count_q <= count_q + CNT_W'(1);
						state_q <= S_UPA;
					end
				end
				S_POP0: state_q <= S_POP1;
				S_POP1: begin
					pop_h_q  <= rd_h;
					pop_c_q  <= rd_c;
					popped_q <= 1'b1;
					state_q  <= S_POP2;
				end
				S_POP2: begin
					cur_h_q <= rd_h;
					cur_c_q <= rd_c;
					pos_q   <= '0;
					count_q <= count_m1;
					rekey_q <= 1'b1;
					state_q <= (count_m1 == '0) ? S_ROOT : S_DNA;
				end
				S_UPA: begin
					if (pos_q == '0) begin
						state_q <= (rekey_q && !moved_q) ? S_DNA : S_FIN;
					end else begin
						state_q <= S_UPB;
					end
				end
				S_UPB: begin
					if (rd_c > cur_c_q) begin
						pos_q   <= parent;
						moved_q <= 1'b1;
						state_q <= S_UPA;
					end else begin
						state_q <= (rekey_q && !moved_q) ? S_DNA : S_FIN;
					end
				end
				S_DNA: state_q <= left_ok ? S_DNB : S_FIN;
				S_DNB: begin
					left_h_q <= rd_h;
					left_c_q <= rd_c;
					state_q  <= S_DNC;
				end
				S_DNC: begin
					if (pick_c < cur_c_q) begin
						pos_q   <= pick_i;
						state_q <= S_DNA;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN:  state_q <= S_ROOT;
				S_ROOT: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						out_node_id <= popped_q ? pop_h_q : '0;
						out_cost    <= popped_q ? 32'(pop_c_q) :
							(count_q == '0) ? 32'd0 : 32'(rd_c);
						status      <= status_q;
						entry_count <= count_q;
						heap_empty  <= (count_q == '0);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* design/imh_checker.sv */
// Port-level assertions for the indexed min-heap queue, bound to the top level.
// Depends on imh_pkg.
module imh_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [imh_pkg::NODE_W-1:0]  out_node_id,
	input logic [1:0]                  status,
	input logic [imh_pkg::CNT_W-1:0]   entry_count,
	input logic                        heap_empty
);
	import imh_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_count) && $stable(status))
		else $error("result dropped or changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heap_empty == (entry_count == '0))
		else $error("empty flag disagrees with count");

	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_node_id == '0)
		else $error("failed transaction returned a handle");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transaction while busy");
endmodule

bind indexed_min_heap_queue_top imh_checker u_imh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_node_id(out_node_id),
	.status(status), .entry_count(entry_count), .heap_empty(heap_empty)
);
